>>> rtl/json_string_escaper_core_macros.svh
// Assertion macros shared by the checker of the JSON string escaper core.
// Holds concurrent assertion shorthands only; no other dependencies.
`ifndef JSON_STRING_ESCAPER_CORE_MACROS_SVH
`define JSON_STRING_ESCAPER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JSE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("jse: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("jse: next-cycle check failed");

`endif

>>> rtl/jse_pkg.sv
// Package for the JSON string escaper core: widths, status codes, character
// constants and the hex digit helpers. It depends on nothing else.
`timescale 1ns / 1ps

package jse_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int CFG_W       = 16;
    localparam int CP_W        = 21;
    localparam int ESC_MAX     = 12;
    localparam int OBUF_DEPTH  = ESC_MAX + 1;
    localparam int CNT_W       = $clog2(OBUF_DEPTH + 1);

    localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 16'd240;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_UTF8 = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // Code point limits.
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10ffff;
    localparam logic [CP_W-1:0] CP_BMP_MAX  = 21'h00ffff;
    localparam logic [CP_W-1:0] CP_SUPP     = 21'h010000;
    localparam logic [CP_W-1:0] CP_MIN2     = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
    localparam logic [CP_W-1:0] SURR_FIRST  = 21'h00d800;
    localparam logic [CP_W-1:0] SURR_LAST   = 21'h00dfff;
    localparam logic [15:0]     HIGH_SURR   = 16'hd800;
    localparam logic [15:0]     LOW_SURR    = 16'hdc00;

    // Lead byte ranges.
    localparam logic [7:0] LEAD2_MIN = 8'hc2;
    localparam logic [7:0] LEAD2_MAX = 8'hdf;
    localparam logic [7:0] LEAD3_MIN = 8'he0;
    localparam logic [7:0] LEAD3_MAX = 8'hef;
    localparam logic [7:0] LEAD4_MIN = 8'hf0;
    localparam logic [7:0] LEAD4_MAX = 8'hf4;

    // Characters.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] HEX_ALPHA = 8'h57;

    typedef logic [5:0][7:0] uesc_t;

    // Lowercase hex digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'b0000, nib};
        end else begin
            return HEX_ALPHA + {4'b0000, nib};
        end
    endfunction

    // The six bytes of a \uXXXX escape, first byte in element 0.
    function automatic uesc_t u_escape(input logic [15:0] v);
        uesc_t r;
        r[0] = CH_BSLASH;
        r[1] = CH_U;
        r[2] = hex_char(v[15:12]);
        r[3] = hex_char(v[11:8]);
        r[4] = hex_char(v[7:4]);
        r[5] = hex_char(v[3:0]);
        return r;
    endfunction

endpackage

>>> rtl/json_string_escaper_core.sv
// The first result of an accepted transaction is on the master side in the cycle after it.
// Throughput: one input transaction per cycle while each gives at most one result and
// m_axis_tready is high; else the next waits for the last result of the single output stage.
// Reset: synchronous, active low; clears the decoder, counters and output stage and
// restores max_bytes to 240. Uses jse_pkg.
`timescale 1ns / 1ps

module json_string_escaper_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: max_bytes.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // last
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser,   // [0] out_valid, [2:1] status
    output logic        m_axis_tlast    // end_of_string
);

    localparam int LB = jse_pkg::LENGTH_BITS;
    localparam int CW = jse_pkg::CNT_W;
    // Largest count that a length counter can hold.
    localparam logic [31:0] LEN_MAX = 32'((64'd1 << LB) - 64'd1);

    // Configuration and per-string decoder state.
    logic [15:0]             max_bytes_reg;
    logic [jse_pkg::CP_W-1:0] acc_reg, acc_next;
    logic [1:0]              pend_reg, pend_next;
    logic [1:0]              slen_reg, slen_next;
    logic [LB-1:0]           inc_reg, inc_next;
    logic [LB-1:0]           outc_reg, outc_next;
    jse_pkg::status_t        err_reg, err_next;

    // Output stage: a shift line of result bytes, drained from element 0.
    logic [7:0]              obuf_reg [jse_pkg::OBUF_DEPTH];
    logic [7:0]              obuf_next [jse_pkg::OBUF_DEPTH];
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    eos_reg, eos_next;
    logic                    extra_reg, extra_next;
    jse_pkg::status_t        fin_reg, fin_next;

    // Combinational working values.
    logic [7:0]              esc [jse_pkg::OBUF_DEPTH];
    logic [3:0]              n_esc;
    logic [3:0]              n_emit;
    logic [LB-1:0]           limit;
    logic [LB-1:0]           room;
    logic [jse_pkg::CP_W-1:0] cp_min;
    logic [jse_pkg::CP_W-1:0] supp;
    jse_pkg::uesc_t          u_hi, u_lo;
    logic [7:0]              b;
    logic                    s_acc, m_acc;

    assign b     = s_axis_tdata;
    assign s_acc = s_axis_tvalid & s_axis_tready;
    assign m_acc = m_axis_tvalid & m_axis_tready;

    // The limit saturates at the largest count that the length counters can hold.
    assign limit = (32'(max_bytes_reg) > LEN_MAX) ? LB'(LEN_MAX) : LB'(max_bytes_reg);

    // A new transaction is taken when the output stage is empty or hands over its final result.
    assign s_axis_tready = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && m_axis_tready);

    // The final element may be the byte-less end-of-string result, which carries the status.
    assign m_axis_tvalid   = (cnt_reg != '0);
    assign m_axis_tdata    = obuf_reg[0];
    assign m_axis_tlast    = eos_reg && (cnt_reg == CW'(1));
    assign m_axis_tuser[0] = !(extra_reg && (cnt_reg == CW'(1)));
    assign m_axis_tuser[2:1] = (extra_reg && (cnt_reg == CW'(1))) ? fin_reg : jse_pkg::ST_OK;

    // Decode and escape one input byte in a single pass.
    always_comb begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        slen_next = slen_reg;
        inc_next  = inc_reg;
        outc_next = outc_reg;
        err_next  = err_reg;
        n_esc     = 4'd0;
        cp_min    = jse_pkg::CP_SUPP;
        supp      = acc_reg - jse_pkg::CP_SUPP;
        u_hi      = jse_pkg::u_escape(16'h0000);
        u_lo      = jse_pkg::u_escape(16'h0000);
        for (int i = 0; i < jse_pkg::OBUF_DEPTH; i++) begin
            esc[i] = 8'h00;
        end

        if (s_axis_tuser[0] && (err_reg == jse_pkg::ST_OK)) begin
            if (inc_reg >= limit) begin
                err_next = jse_pkg::ST_TOO_LONG;
            end else begin
                inc_next = inc_reg + LB'(1);
                if (pend_reg != 2'd0) begin
                    if (b[7:6] != 2'b10) begin
                        // A broken sequence drops the offending byte.
                        err_next = jse_pkg::ST_BAD_UTF8;
                    end else begin
                        acc_next  = {acc_reg[jse_pkg::CP_W-7:0], b[5:0]};
                        pend_next = pend_reg - 2'd1;
                        if (pend_next == 2'd0) begin
                            slen_next = 2'd0;
                            case (slen_reg)
                                2'd1:    cp_min = jse_pkg::CP_MIN2;
                                2'd2:    cp_min = jse_pkg::CP_MIN3;
                                default: cp_min = jse_pkg::CP_SUPP;
                            endcase
                            supp = acc_next - jse_pkg::CP_SUPP;
                            if ((acc_next < cp_min) || (acc_next > jse_pkg::CP_MAX) ||
                                ((acc_next >= jse_pkg::SURR_FIRST) &&
                                 (acc_next <= jse_pkg::SURR_LAST))) begin
                                err_next = jse_pkg::ST_BAD_UTF8;
                            end else if (acc_next <= jse_pkg::CP_BMP_MAX) begin
                                u_hi = jse_pkg::u_escape(acc_next[15:0]);
                                for (int i = 0; i < 6; i++) begin
                                    esc[i] = u_hi[i];
                                end
                                n_esc = 4'd6;
                            end else begin
                                // Supplementary plane: surrogate pair.
                                u_hi = jse_pkg::u_escape(jse_pkg::HIGH_SURR +
                                                         {6'b000000, supp[19:10]});
                                u_lo = jse_pkg::u_escape(jse_pkg::LOW_SURR +
                                                         {6'b000000, supp[9:0]});
                                for (int i = 0; i < 6; i++) begin
                                    esc[i]     = u_hi[i];
                                    esc[i + 6] = u_lo[i];
                                end
                                n_esc = 4'd12;
                            end
                        end
                    end
                end else if (!b[7]) begin
                    case (b)
                        jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH: begin
                            esc[0] = jse_pkg::CH_BSLASH;
                            esc[1] = b;
                            n_esc  = 4'd2;
                        end
                        jse_pkg::CH_BS: begin
                            esc[0] = jse_pkg::CH_BSLASH;
                            esc[1] = jse_pkg::CH_B;
                            n_esc  = 4'd2;
                        end
                        jse_pkg::CH_FF: begin
                            esc[0] = jse_pkg::CH_BSLASH;
                            esc[1] = jse_pkg::CH_F;
                            n_esc  = 4'd2;
                        end
                        jse_pkg::CH_LF: begin
                            esc[0] = jse_pkg::CH_BSLASH;
                            esc[1] = jse_pkg::CH_N;
                            n_esc  = 4'd2;
                        end
                        jse_pkg::CH_CR: begin
                            esc[0] = jse_pkg::CH_BSLASH;
                            esc[1] = jse_pkg::CH_R;
                            n_esc  = 4'd2;
                        end
                        jse_pkg::CH_TAB: begin
                            esc[0] = jse_pkg::CH_BSLASH;
                            esc[1] = jse_pkg::CH_T;
                            n_esc  = 4'd2;
                        end
                        default: begin
                            if (b < jse_pkg::CH_SPACE) begin
                                u_hi = jse_pkg::u_escape({8'h00, b});
                                for (int i = 0; i < 6; i++) begin
                                    esc[i] = u_hi[i];
                                end
                                n_esc = 4'd6;
                            end else begin
                                esc[0] = b;
                                n_esc  = 4'd1;
                            end
                        end
                    endcase
                end else if ((b >= jse_pkg::LEAD2_MIN) && (b <= jse_pkg::LEAD2_MAX)) begin
                    slen_next = 2'd1;
                    pend_next = 2'd1;
                    acc_next  = {16'h0000, b[4:0]};
                end else if ((b >= jse_pkg::LEAD3_MIN) && (b <= jse_pkg::LEAD3_MAX)) begin
                    slen_next = 2'd2;
                    pend_next = 2'd2;
                    acc_next  = {17'h00000, b[3:0]};
                end else if ((b >= jse_pkg::LEAD4_MIN) && (b <= jse_pkg::LEAD4_MAX)) begin
                    slen_next = 2'd3;
                    pend_next = 2'd3;
                    acc_next  = {18'h00000, b[2:0]};
                end else begin
                    err_next = jse_pkg::ST_BAD_UTF8;
                end
            end
        end

        // Output length check: emit what still fits, flag the rest.
        room = (outc_reg >= limit) ? '0 : (limit - outc_reg);
        if (LB'(n_esc) <= room) begin
            n_emit = n_esc;
        end else begin
            n_emit   = room[3:0];
            err_next = jse_pkg::ST_TOO_LONG;
        end
        outc_next = outc_reg + LB'(n_emit);

        eos_next   = 1'b0;
        extra_next = 1'b0;
        fin_next   = jse_pkg::ST_OK;
        cnt_next   = CW'(n_emit);
        if (s_axis_tlast) begin
            if ((err_next == jse_pkg::ST_OK) && (pend_next != 2'd0)) begin
                err_next = jse_pkg::ST_BAD_UTF8;
            end
            eos_next = 1'b1;
            fin_next = err_next;
            if (!((err_next == jse_pkg::ST_OK) && (n_emit != 4'd0))) begin
                // A separate byte-less result closes the string.
                extra_next = 1'b1;
                cnt_next   = CW'(n_emit) + CW'(1);
            end
            acc_next  = '0;
            pend_next = 2'd0;
            slen_next = 2'd0;
            inc_next  = '0;
            outc_next = '0;
            err_next  = jse_pkg::ST_OK;
        end

        // Unused slots are zero so that the end-of-string result carries a zero byte.
        for (int i = 0; i < jse_pkg::OBUF_DEPTH; i++) begin
            obuf_next[i] = (CW'(i) < CW'(n_emit)) ? esc[i] : 8'h00;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= jse_pkg::MAX_BYTES_RESET;
            acc_reg       <= '0;
            pend_reg      <= 2'd0;
            slen_reg      <= 2'd0;
            inc_reg       <= '0;
            outc_reg      <= '0;
            err_reg       <= jse_pkg::ST_OK;
            cnt_reg       <= '0;
            eos_reg       <= 1'b0;
            extra_reg     <= 1'b0;
            fin_reg       <= jse_pkg::ST_OK;
        end else begin
            if (cfg_we) begin
                max_bytes_reg <= cfg_wdata;
            end
            if (s_acc) begin
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                slen_reg  <= slen_next;
                inc_reg   <= inc_next;
                outc_reg  <= outc_next;
                err_reg   <= err_next;
                cnt_reg   <= cnt_next;
                eos_reg   <= eos_next;
                extra_reg <= extra_next;
                fin_reg   <= fin_next;
            end else if (m_acc) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // Result bytes: loaded on a new transaction, shifted down as results leave.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < jse_pkg::OBUF_DEPTH; i++) begin
                obuf_reg[i] <= obuf_next[i];
            end
        end else if (m_acc) begin
            for (int i = 0; i < jse_pkg::OBUF_DEPTH - 1; i++) begin
                obuf_reg[i] <= obuf_reg[i + 1];
            end
            obuf_reg[jse_pkg::OBUF_DEPTH - 1] <= 8'h00;
        end
    end

endmodule

>>> rtl/jse_checker.sv
// Port-level checks for the JSON string escaper core, bound to the top level.
// Uses jse_pkg and the macros in json_string_escaper_core_macros.svh.
`timescale 1ns / 1ps
`include "json_string_escaper_core_macros.svh"

module jse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result keeps its payload.
    `JSE_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // A result carrying a byte always has an ok status.
    `JSE_ASSERT_SAME(a_byte_status_ok, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == jse_pkg::ST_OK)

    // A byte-less result only ever closes a string, with a zero byte.
    `JSE_ASSERT_SAME(a_empty_is_end, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == 8'h00))

    // The escaped output is pure ASCII.
    `JSE_ASSERT_SAME(a_ascii_only, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], !m_axis_tdata[7])

    // The status code never takes the unused value.
    `JSE_ASSERT_SAME(a_status_range, aclk, aresetn, m_axis_tvalid, m_axis_tuser[2:1] != 2'b11)

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (.*);
